// ===== hw/rtl/ede_pkg.sv =====
// Shared types and codes for the edit distance engine.
package ede_pkg;

	localparam int CHAR_W = 8;
	localparam int DIST_W = 7;

	localparam logic [1:0] OP_FIRST  = 2'd0;
	localparam logic [1:0] OP_SECOND = 2'd1;
	localparam logic [1:0] OP_FINISH = 2'd2;

	typedef struct packed {
		logic [1:0]        op;
		logic [CHAR_W-1:0] char_value;
	} item_t;

	typedef struct packed {
		logic [DIST_W-1:0] distance;
		logic              overflow;
	} result_t;

endpackage

// ===== hw/rtl/ede_cell.sv =====
// Shared cost unit: one cell of the insert, delete and substitute recurrence.
module ede_cell import ede_pkg::*; #(
	parameter int W = 7
) (
	input  logic [W-1:0]      diag,
	input  logic [W-1:0]      up,
	input  logic [W-1:0]      left,
	input  logic [CHAR_W-1:0] a,
	input  logic [CHAR_W-1:0] b,
	output logic [W-1:0]      cost
);

	logic [W:0] up_c;
	logic [W:0] left_c;
	logic [W:0] sub_c;
	logic [W:0] min_ul;
	logic [W:0] min_all;

	assign up_c    = {1'b0, up} + 1'b1;
	assign left_c  = {1'b0, left} + 1'b1;
	assign sub_c   = {1'b0, diag} + {{W{1'b0}}, (a != b)};
	assign min_ul  = (up_c < left_c) ? up_c : left_c;
	assign min_all = (min_ul < sub_c) ? min_ul : sub_c;
	assign cost    = min_all[W-1:0];

endmodule

// ===== hw/rtl/edit_distance_engine.sv =====
// Levenshtein edit distance engine: string stores, column store and sequencer.
// Append items are taken back to back while the sequencer is idle.
// A finish item starts the sweep of the single shared cost unit, which works one cell
// at a time in a read state and a calculate state over the column store port.
// The result sits in an output register; loads are taken while it waits.
// Reset clears lengths, overflow flag and sequencer; string and column stores keep contents.
module edit_distance_engine import ede_pkg::*; #(
	parameter int MAX_LEN = 64
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_ready,
	output result_t result
);

	localparam int LW = $clog2(MAX_LEN + 1);
	localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_INIT = 6'b000010,
		ST_ROW  = 6'b000100,
		ST_RD   = 6'b001000,
		ST_CALC = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t            state_q;
	logic [LW-1:0]     len1_q;
	logic [LW-1:0]     len2_q;
	logic              ovf_q;
	logic [LW-1:0]     i_q;
	logic [LW-1:0]     j_q;
	logic [LW-1:0]     diag_q;
	logic [LW-1:0]     left_q;
	logic              result_valid_q;
	result_t           result_q;

	logic [CHAR_W-1:0] first_mem [MAX_LEN];
	logic [CHAR_W-1:0] second_mem [MAX_LEN];
	logic [LW-1:0]     col_mem [MAX_LEN+1];
	logic [CHAR_W-1:0] a_rd_q;
	logic [CHAR_W-1:0] b_rd_q;
	logic [LW-1:0]     col_rd_q;

	logic              accept;
	logic              load;
	logic [LW:0]       i_next;
	logic [LW:0]       j_next;
	logic              row_last;
	logic              col_last;
	logic [LW-1:0]     cell_cost;
	logic [LW-1:0]     final_dist;

	assign item_ready   = (state_q == ST_IDLE);
	assign accept       = item_valid && item_ready;
	assign load         = (state_q == ST_DONE) && (!result_valid_q || result_ready);
	assign i_next       = {1'b0, i_q} + 1'b1;
	assign j_next       = {1'b0, j_q} + 1'b1;
	assign row_last     = (i_next == {1'b0, len1_q});
	assign col_last     = (j_next == {1'b0, len2_q});
	assign final_dist   = (len1_q == '0) ? len2_q : left_q;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	ede_cell #(
		.W(LW)
	) u_cell (
		.diag(diag_q),
		.up  (col_rd_q),
		.left(left_q),
		.a   (a_rd_q),
		.b   (b_rd_q),
		.cost(cell_cost)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			len1_q         <= '0;
			len2_q         <= '0;
			ovf_q          <= 1'b0;
			i_q            <= '0;
			j_q            <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.op)
							OP_FIRST: begin
								if (len1_q < LW'(MAX_LEN)) begin
									len1_q <= LW'({1'b0, len1_q} + 1'b1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							OP_SECOND: begin
								if (len2_q < LW'(MAX_LEN)) begin
									len2_q <= LW'({1'b0, len2_q} + 1'b1);
								end else begin
									ovf_q <= 1'b1;
								end
							end
							OP_FINISH: begin
								j_q     <= '0;
								state_q <= ST_INIT;
							end
							default: begin
							end
						endcase
					end
				end
				ST_INIT: begin
					if (j_q == len2_q) begin
						i_q     <= '0;
						state_q <= (len1_q == '0) ? ST_DONE : ST_ROW;
					end else begin
						j_q <= j_next[LW-1:0];
					end
				end
				ST_ROW: begin
					j_q <= '0;
					if (len2_q != '0) begin
						state_q <= ST_RD;
					end else if (row_last) begin
						state_q <= ST_DONE;
					end else begin
						i_q <= i_next[LW-1:0];
					end
				end
				ST_RD: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (col_last) begin
						if (row_last) begin
							state_q <= ST_DONE;
						end else begin
							i_q     <= i_next[LW-1:0];
							state_q <= ST_ROW;
						end
					end else begin
						j_q     <= j_next[LW-1:0];
						state_q <= ST_RD;
					end
				end
				ST_DONE: begin
					if (load) begin
						len1_q  <= '0;
						len2_q  <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ROW) begin
			diag_q <= i_q;
			left_q <= i_next[LW-1:0];
		end else if (state_q == ST_CALC) begin
			diag_q <= col_rd_q;
			left_q <= cell_cost;
		end
		if (load) begin
			result_q.distance <= DIST_W'(final_dist);
			result_q.overflow <= ovf_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.op == OP_FIRST && len1_q < LW'(MAX_LEN)) begin
			first_mem[len1_q[AW-1:0]] <= item.char_value;
		end
		if (state_q == ST_ROW) begin
			a_rd_q <= first_mem[i_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.op == OP_SECOND && len2_q < LW'(MAX_LEN)) begin
			second_mem[len2_q[AW-1:0]] <= item.char_value;
		end
		if (state_q == ST_RD) begin
			b_rd_q <= second_mem[j_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_INIT) begin
			col_mem[j_q] <= j_q;
		end else if (state_q == ST_CALC) begin
			col_mem[j_next[LW-1:0]] <= cell_cost;
		end
		if (state_q == ST_RD) begin
			col_rd_q <= col_mem[j_next[LW-1:0]];
		end
	end

`ifndef SYNTHESIS
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len1_q <= LW'(MAX_LEN) && len2_q <= LW'(MAX_LEN))
		else $error("string length beyond capacity");

	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CALC || state_q == ST_RD) |-> (j_q < len2_q && i_q < len1_q))
		else $error("cell index outside loaded strings");

	a_finish_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.op == OP_FINISH) |=> (state_q == ST_INIT && j_q == '0))
		else $error("finish transfer did not start the sweep");

	a_result_load: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (result_valid && state_q == ST_IDLE && len1_q == '0 && len2_q == '0
			&& !ovf_q))
		else $error("result not presented or lengths not cleared");
`endif

endmodule

// ===== tb/tb.sv =====
// Testbench for the edit distance engine: directed and random string pairs.
module tb;
	import ede_pkg::*;

	localparam int MAX_LEN = 64;
	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int ITEMS_PER_PHASE = 110;
	localparam int DRAIN_CYCLES = 200;
	localparam int MAX_REPORTS = 40;

	typedef logic [CHAR_W-1:0] char_queue_t[$];

	logic    clk = 1'b0;
	logic    arst_n;
	logic    item_valid;
	logic    item_ready;
	item_t   item;
	logic    result_valid;
	logic    result_ready;
	result_t result;

	int send_idle;
	int recv_idle;
	int mismatches;
	int items_sent;

	logic [CHAR_W-1:0] first_bytes [MAX_LEN];
	logic [CHAR_W-1:0] second_bytes [MAX_LEN];
	int      first_len;
	int      second_len;
	logic    bytes_dropped;
	result_t pending_distances[$];

	edit_distance_engine #(.MAX_LEN(MAX_LEN)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	always #10 clk = ~clk;

	function automatic result_t levenshtein();
		int costs [MAX_LEN+1];
		int diag;
		int up;
		int sub;
		int best;
		result_t r;
		for (int j = 0; j <= second_len; j++)
			costs[j] = j;
		for (int i = 0; i < first_len; i++) begin
			diag = costs[0];
			costs[0] = i + 1;
			for (int j = 0; j < second_len; j++) begin
				up = costs[j+1];
				sub = diag + ((first_bytes[i] == second_bytes[j]) ? 0 : 1);
				best = up + 1;
				if (costs[j] + 1 < best)
					best = costs[j] + 1;
				if (sub < best)
					best = sub;
				costs[j+1] = best;
				diag = up;
			end
		end
		r.distance = DIST_W'(costs[second_len]);
		r.overflow = bytes_dropped;
		return r;
	endfunction

	function automatic void apply_item(input item_t it);
		case (it.op)
			OP_FIRST: begin
				if (first_len < MAX_LEN) begin
					first_bytes[first_len] = it.char_value;
					first_len++;
				end else begin
					bytes_dropped = 1'b1;
				end
			end
			OP_SECOND: begin
				if (second_len < MAX_LEN) begin
					second_bytes[second_len] = it.char_value;
					second_len++;
				end else begin
					bytes_dropped = 1'b1;
				end
			end
			OP_FINISH: begin
				pending_distances.push_back(levenshtein());
				first_len = 0;
				second_len = 0;
				bytes_dropped = 1'b0;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic logic [CHAR_W-1:0] pick_char(input bit wide);
		if (wide)
			return CHAR_W'($urandom_range(255));
		return 8'h61 + CHAR_W'($urandom_range(3));
	endfunction

	function automatic char_queue_t make_string(input int n, input bit wide);
		char_queue_t s;
		repeat (n) s.push_back(pick_char(wide));
		return s;
	endfunction

	function automatic char_queue_t derive_string(input char_queue_t src, input int edits,
		input bit wide);
		char_queue_t s;
		int pos;
		s = src;
		repeat (edits) begin
			case ($urandom_range(2))
				0: begin
					pos = $urandom_range(s.size());
					s.insert(pos, pick_char(wide));
				end
				1: begin
					if (s.size() != 0)
						s.delete($urandom_range(s.size() - 1));
				end
				default: begin
					if (s.size() != 0)
						s[$urandom_range(s.size() - 1)] = pick_char(wide);
				end
			endcase
		end
		return s;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("mismatch at %0t: %s", $time, msg);
	endtask

	task automatic check_result(input result_t got);
		result_t want;
		if (pending_distances.size() == 0) begin
			report_mismatch($sformatf("unexpected result, distance %0d overflow %0b",
				got.distance, got.overflow));
			return;
		end
		want = pending_distances.pop_front();
		if (got.distance !== want.distance)
			report_mismatch($sformatf("distance %0d, predicted %0d", got.distance, want.distance));
		if (got.overflow !== want.overflow)
			report_mismatch($sformatf("overflow %0b, predicted %0b", got.overflow, want.overflow));
	endtask

	always @(posedge clk) begin
		if (result_valid && result_ready)
			check_result(result);
		result_ready <= ($urandom_range(99) >= recv_idle);
	end

	task automatic send_item(input logic [1:0] op, input logic [CHAR_W-1:0] ch);
		item_t it;
		it.op = op;
		it.char_value = ch;
		while ($urandom_range(99) < send_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		apply_item(it);
		items_sent++;
	endtask

	task automatic send_pair(input char_queue_t a, input char_queue_t b);
		int ia;
		int ib;
		ia = 0;
		ib = 0;
		while (ia < a.size() || ib < b.size()) begin
			if (ib >= b.size() || (ia < a.size() && $urandom_range(1) == 0)) begin
				send_item(OP_FIRST, a[ia]);
				ia++;
			end else begin
				send_item(OP_SECOND, b[ib]);
				ib++;
			end
		end
		send_item(OP_FINISH, CHAR_W'($urandom_range(255)));
	endtask

	task automatic wait_for_results();
		while (pending_distances.size() != 0) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic test_empty_strings();
		char_queue_t none;
		none = '{};
		send_pair(none, none);
		send_pair('{8'h61, 8'h62, 8'h63}, none);
		send_pair(none, '{8'h78, 8'h79});
	endtask

	task automatic test_byte_extremes();
		send_pair('{8'h00, 8'hFF}, '{8'h00, 8'hFF});
		send_pair('{8'h41}, '{8'h61});
		send_pair('{8'hFF, 8'h00}, '{8'h00, 8'hFF});
	endtask

	task automatic test_unused_selector();
		send_item(OP_FIRST, 8'h61);
		send_item(OP_SPARE, 8'hFF);
		send_item(OP_SECOND, 8'h62);
		send_item(OP_SPARE, 8'h00);
		send_item(OP_FINISH, 8'h00);
	endtask

	task automatic test_long_strings();
		bit wide;
		char_queue_t a;
		wide = ($urandom_range(9) < 3);
		// overfill the first string, leave the second empty
		send_pair(make_string(MAX_LEN + $urandom_range(1, 2), wide), '{});
		a = make_string(MAX_LEN, wide);
		send_pair(a, derive_string(a, $urandom_range(0, 4), wide));
	endtask

	task automatic test_random_traffic(input int sender_idle, input int receiver_idle);
		int start;
		int kind;
		bit wide;
		char_queue_t a;
		char_queue_t b;
		send_idle = sender_idle;
		recv_idle = receiver_idle;
		start = items_sent;
		for (int s = 0; items_sent - start < ITEMS_PER_PHASE; s++) begin
			wide = ($urandom_range(9) < 3);
			kind = $urandom_range(99);
			if (kind < 4) begin
				a = make_string($urandom_range(40, MAX_LEN + 2), wide);
				if ($urandom_range(1))
					b = derive_string(a, $urandom_range(0, 6), wide);
				else
					b = make_string($urandom_range(0, MAX_LEN + 2), wide);
				send_pair(a, b);
			end else if (kind < 14) begin
				repeat ($urandom_range(1, 6))
					send_item(2'($urandom_range(3)), CHAR_W'($urandom_range(255)));
			end else begin
				a = make_string($urandom_range(0, 8), wide);
				if ($urandom_range(1))
					b = derive_string(a, $urandom_range(0, 3), wide);
				else
					b = make_string($urandom_range(0, 8), wide);
				send_pair(a, b);
			end
			if (s == 6)
				wait_for_results();
		end
		wait_for_results();
	endtask

	initial begin
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
		mismatches = 0;
		items_sent = 0;
		first_len = 0;
		second_len = 0;
		bytes_dropped = 1'b0;
		send_idle = 11;
		recv_idle = 52;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_strings();
		test_byte_extremes();
		test_unused_selector();
		test_long_strings();
		wait_for_results();
		test_random_traffic(11, 52);
		test_random_traffic(52, 11);
		test_random_traffic(0, 0);

		item_valid <= 1'b0;
		while (pending_distances.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0 && pending_distances.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	initial begin
		#40000000;
		$display("FAIL");
		$finish;
	end

endmodule
